/* src/skid_steer_slew_limited_drive_defines.svh */
// Assertion macros shared by the drive mixer modules.
`ifndef SKID_STEER_SLEW_LIMITED_DRIVE_DEFINES_SVH
`define SKID_STEER_SLEW_LIMITED_DRIVE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ssd_pkg.sv */
// Package with shared types and constants of the drive mixer.
`timescale 1ns / 1ps

package ssd_pkg;

  localparam int FIELD_WIDTH     = 16;
  localparam int STEP_WIDTH      = 15;
  localparam int GAIN_WIDTH      = 16;
  localparam int COUNT_WIDTH     = 16;
  localparam int FRAC_BITS       = 12;
  localparam int UNIT_VALUE      = 4096;
  localparam int CHANNELS        = 4;
  localparam int CH_WIDTH        = 2;
  localparam int MIX_WIDTH       = 18;
  localparam int MAG_WIDTH       = 17;
  localparam int QUOT_WIDTH      = 13;
  localparam int BASE_WIDTH      = 14;
  localparam int PROD_WIDTH      = 30;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 16;

  localparam logic OP_COMMAND = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_COMMAND_STEP  = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MOTOR_STEP    = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEAD_BAND     = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FRONT_GAIN    = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_REAR_GAIN     = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TIMEOUT_TICKS = 3'd5;

  typedef struct packed {
    logic                          operation;
    logic signed [FIELD_WIDTH-1:0] fwd_speed;
    logic signed [FIELD_WIDTH-1:0] turn_rate;
  } item_t;

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] left_front_speed;
    logic signed [FIELD_WIDTH-1:0] left_rear_speed;
    logic signed [FIELD_WIDTH-1:0] right_front_speed;
    logic signed [FIELD_WIDTH-1:0] right_rear_speed;
    logic                          timed_out;
  } result_t;

  typedef struct packed {
    logic [STEP_WIDTH-1:0] step;
    logic [STEP_WIDTH-1:0] dead_band;
    logic                  zero_small;
  } slew_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef struct packed {
    logic                valid;
    logic [CH_WIDTH-1:0] ch;
  } gain_tag_t;

endpackage

/* src/ssd_item_if.sv */
// Stream interface carrying command and tick items.
`timescale 1ns / 1ps

interface ssd_item_if;
  logic           valid;
  logic           ready;
  ssd_pkg::item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/ssd_result_if.sv */
// Stream interface carrying modeled motor speed reports.
`timescale 1ns / 1ps

interface ssd_result_if;
  logic             valid;
  logic             ready;
  ssd_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/ssd_divider.sv */
// Restoring divider that scales a magnitude by 4096 over its maximum, one bit a cycle.
`timescale 1ns / 1ps
`include "skid_steer_slew_limited_drive_defines.svh"

module ssd_divider (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [ssd_pkg::MAG_WIDTH-1:0]       dividend,
  input  logic [ssd_pkg::MAG_WIDTH-1:0]       divisor,
  output ssd_pkg::div_status_t                status,
  output logic [ssd_pkg::QUOT_WIDTH-1:0]      quotient
);

  localparam int MW = ssd_pkg::MAG_WIDTH;
  localparam int QW = ssd_pkg::QUOT_WIDTH;
  localparam int CW = $clog2(QW + 1);

  logic [MW:0]   rem;
  logic [MW-1:0] den;
  logic [CW-1:0] count;
  logic          busy;
  logic          done;
  logic [MW:0]   den_x;
  logic          take;
  logic [MW:0]   rem_sub;

  assign den_x   = {1'b0, den};
  assign take    = rem >= den_x;
  assign rem_sub = take ? rem - den_x : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(QW);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= {1'b0, dividend};
      den      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      quotient <= {quotient[QW-2:0], take};
      rem      <= {rem_sub[MW-1:0], 1'b0};
    end
  end

  assign status.busy = busy;
  assign status.done = done;

  `SSD_ASSERT_NOW(a_quotient_bound, done, quotient <= QW'(ssd_pkg::UNIT_VALUE), "quotient exceeds unit")

endmodule

/* src/ssd_gain.sv */
// Shared gain unit: registered multiply, then rounding and saturation.
`timescale 1ns / 1ps

module ssd_gain #(
  parameter int W = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  ssd_pkg::gain_tag_t                     tag_in,
  input  logic signed [ssd_pkg::BASE_WIDTH-1:0]  base,
  input  logic signed [ssd_pkg::GAIN_WIDTH-1:0]  gain,
  output ssd_pkg::gain_tag_t                     tag_out,
  output logic signed [W-1:0]                    result
);

  localparam int PW = ssd_pkg::PROD_WIDTH;
  localparam int FB = ssd_pkg::FRAC_BITS;
  localparam int RW = PW - FB + 1;
  localparam int EW = (W > RW) ? W : RW;
  localparam logic signed [EW-1:0] MAX_E = EW'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [EW-1:0] MIN_E = ~MAX_E;

  logic signed [PW-1:0] prod;
  logic [PW-1:0]        prod_mag;
  logic [PW-1:0]        prod_round;
  logic signed [RW-1:0] rounded_pos;
  logic signed [RW-1:0] rounded;
  logic signed [EW-1:0] rounded_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else begin
      tag_out <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (tag_in.valid) begin
      prod <= base * gain;
    end
  end

  assign prod_mag    = prod[PW-1] ? PW'(-prod) : PW'(prod);
  assign prod_round  = prod_mag + PW'(ssd_pkg::UNIT_VALUE / 2);
  assign rounded_pos = $signed({1'b0, prod_round[PW-1:FB]});
  assign rounded     = prod[PW-1] ? -rounded_pos : rounded_pos;
  assign rounded_x   = EW'(rounded);

  always_comb begin
    if (rounded_x > MAX_E) begin
      result = W'(MAX_E);
    end else if (rounded_x < MIN_E) begin
      result = W'(MIN_E);
    end else begin
      result = W'(rounded_x);
    end
  end

endmodule

/* src/ssd_slew.sv */
// Shared slew unit: steps a value toward a target and, when zero_small is set, zeroes magnitudes below the dead band.
`timescale 1ns / 1ps

module ssd_slew #(
  parameter int W = 16
) (
  input  logic signed [W-1:0] value,
  input  logic signed [W-1:0] target,
  input  ssd_pkg::slew_ctl_t  ctl,
  output logic signed [W-1:0] result
);

  localparam int SW = ssd_pkg::STEP_WIDTH;
  localparam int XW = ((W > SW) ? W : SW) + 2;

  logic signed [XW-1:0] v_x;
  logic signed [XW-1:0] t_x;
  logic signed [XW-1:0] s_x;
  logic signed [XW-1:0] db_x;
  logic signed [XW-1:0] diff;
  logic signed [XW-1:0] diff_mag;
  logic signed [XW-1:0] stepped;
  logic signed [XW-1:0] stepped_mag;
  logic                 below_band;

  assign v_x      = XW'(value);
  assign t_x      = XW'(target);
  assign s_x      = $signed({{(XW - SW){1'b0}}, ctl.step});
  assign db_x     = $signed({{(XW - SW){1'b0}}, ctl.dead_band});
  assign diff     = t_x - v_x;
  assign diff_mag = diff[XW-1] ? -diff : diff;

  always_comb begin
    if (diff_mag > s_x) begin
      stepped = diff[XW-1] ? v_x - s_x : v_x + s_x;
    end else begin
      stepped = t_x;
    end
  end

  assign stepped_mag = stepped[XW-1] ? -stepped : stepped;
  assign below_band  = ctl.zero_small && (stepped_mag < db_x);
  assign result      = below_band ? '0 : W'(stepped);

endmodule

/* src/skid_steer_slew_limited_drive.sv */
// Top level of the skid-steer drive mixer with slew limiting and motor model.
// Items enter on the item channel: a command (linear and angular speed) or a tick.
// A command mixes the speeds into left and right, normalizes them with the shared
// divider when the larger magnitude exceeds 1.0, and sets four wheel targets through
// the shared gain multiplier. It gives no result; when normalizing, two 13-step
// divisions run back to back on one divider.
// A tick ages the idle counter, clears the targets on timeout, and runs the shared
// slew unit eight times (command then motor for each wheel). Its report is loaded
// into the output register in the S_OUT step that follows the slew steps.
// The item channel takes one item at a time; ready is high only while the sequencer
// is idle. A finished report waits in the output register; when the receiver stalls,
// the next command is still accepted, and a following tick holds in its last step
// until the pending report has been transferred.
// Configuration writes are taken at any cycle but must only be issued while idle.
// Synchronous reset restores the register defaults and clears all speeds, targets,
// the idle counter and the output valid.
`timescale 1ns / 1ps
`include "skid_steer_slew_limited_drive_defines.svh"

module skid_steer_slew_limited_drive #(
  parameter int SPEED_WIDTH = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  ssd_item_if.sink                                item,
  ssd_result_if.source                            speeds,
  input  logic                                    cfg_write,
  input  logic [ssd_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
  input  logic [ssd_pkg::CFG_DATA_WIDTH-1:0]      cfg_data
);

  localparam int W  = SPEED_WIDTH;
  localparam int OW = (W > ssd_pkg::FIELD_WIDTH) ? W : ssd_pkg::FIELD_WIDTH;
  localparam int XW = ssd_pkg::MIX_WIDTH;
  localparam int MW = ssd_pkg::MAG_WIDTH;
  localparam int BW = ssd_pkg::BASE_WIDTH;
  localparam int FW = ssd_pkg::FIELD_WIDTH;
  localparam int NCH = ssd_pkg::CHANNELS;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MAG   = 4'd1;
  localparam logic [3:0] S_CMP   = 4'd2;
  localparam logic [3:0] S_DIV_L = 4'd3;
  localparam logic [3:0] S_DIV_R = 4'd4;
  localparam logic [3:0] S_GAIN  = 4'd5;
  localparam logic [3:0] S_AGE   = 4'd6;
  localparam logic [3:0] S_SLEW  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state;

  logic [ssd_pkg::STEP_WIDTH-1:0]         command_step;
  logic [ssd_pkg::STEP_WIDTH-1:0]         motor_step;
  logic [ssd_pkg::STEP_WIDTH-1:0]         dead_band;
  logic signed [ssd_pkg::GAIN_WIDTH-1:0]  front_gain;
  logic signed [ssd_pkg::GAIN_WIDTH-1:0]  rear_gain;
  logic [ssd_pkg::COUNT_WIDTH-1:0]        timeout_ticks;

  logic signed [W-1:0] wheel_target [NCH];
  logic signed [W-1:0] wheel_command [NCH];
  logic signed [W-1:0] motor_speed [NCH];
  logic signed [OW-1:0] motor_x [NCH];
  logic [ssd_pkg::COUNT_WIDTH-1:0] idle_ticks;
  logic timed_out;

  logic signed [XW-1:0] left;
  logic signed [XW-1:0] right;
  logic [MW-1:0]        mag_l;
  logic [MW-1:0]        mag_r;
  logic [MW-1:0]        max_mag;
  logic                 norm_needed;
  logic signed [BW-1:0] base_l;
  logic signed [BW-1:0] base_r;
  logic signed [BW-1:0] quot_pos;
  logic signed [BW-1:0] quot_neg;

  logic [2:0]                       gain_cnt;
  logic [ssd_pkg::CH_WIDTH-1:0]     ch;
  logic                             phase;

  logic                                 accept;
  logic                                 div_start;
  logic [MW-1:0]                        div_dividend;
  ssd_pkg::div_status_t                 div_status;
  logic [ssd_pkg::QUOT_WIDTH-1:0]       div_quotient;

  ssd_pkg::gain_tag_t                   gain_tag_in;
  ssd_pkg::gain_tag_t                   gain_tag_out;
  logic signed [BW-1:0]                 gain_base;
  logic signed [ssd_pkg::GAIN_WIDTH-1:0] gain_coef;
  logic signed [W-1:0]                  gain_result;

  logic signed [W-1:0]  slew_value;
  logic signed [W-1:0]  slew_target;
  ssd_pkg::slew_ctl_t   slew_ctl;
  logic signed [W-1:0]  slew_result;
  logic                 out_free;

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;
  assign out_free   = !speeds.valid || speeds.ready;

  assign max_mag      = (mag_l > mag_r) ? mag_l : mag_r;
  assign norm_needed  = max_mag > MW'(ssd_pkg::UNIT_VALUE);
  assign div_dividend = (state == S_CMP) ? mag_l : mag_r;
  assign div_start    = ((state == S_CMP) && norm_needed) ||
                        ((state == S_DIV_L) && div_status.done);
  assign quot_pos     = $signed({1'b0, div_quotient});
  assign quot_neg     = -quot_pos;

  ssd_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (max_mag),
    .status   (div_status),
    .quotient (div_quotient)
  );

  assign gain_tag_in.valid = (state == S_GAIN) && !gain_cnt[2];
  assign gain_tag_in.ch    = gain_cnt[1:0];
  assign gain_base         = gain_cnt[1] ? base_r : base_l;
  assign gain_coef         = gain_cnt[0] ? rear_gain : front_gain;

  ssd_gain #(.W(W)) u_gain (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (gain_tag_in),
    .base    (gain_base),
    .gain    (gain_coef),
    .tag_out (gain_tag_out),
    .result  (gain_result)
  );

  assign slew_value          = phase ? motor_speed[ch] : wheel_command[ch];
  assign slew_target         = phase ? wheel_command[ch] : wheel_target[ch];
  assign slew_ctl.step       = phase ? motor_step : command_step;
  assign slew_ctl.dead_band  = dead_band;
  assign slew_ctl.zero_small = !phase;

  ssd_slew #(.W(W)) u_slew (
    .value  (slew_value),
    .target (slew_target),
    .ctl    (slew_ctl),
    .result (slew_result)
  );

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      motor_x[i] = OW'(motor_speed[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      command_step  <= 15'd410;
      motor_step    <= 15'd8;
      dead_band     <= 15'd205;
      front_gain    <= 16'sd4096;
      rear_gain     <= 16'sd4096;
      timeout_ticks <= 16'd50;
    end else if (cfg_write) begin
      case (cfg_index)
        ssd_pkg::REG_COMMAND_STEP:  command_step  <= cfg_data[ssd_pkg::STEP_WIDTH-1:0];
        ssd_pkg::REG_MOTOR_STEP:    motor_step    <= cfg_data[ssd_pkg::STEP_WIDTH-1:0];
        ssd_pkg::REG_DEAD_BAND:     dead_band     <= cfg_data[ssd_pkg::STEP_WIDTH-1:0];
        ssd_pkg::REG_FRONT_GAIN:    front_gain    <= $signed(cfg_data);
        ssd_pkg::REG_REAR_GAIN:     rear_gain     <= $signed(cfg_data);
        ssd_pkg::REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      idle_ticks   <= '0;
      timed_out    <= 1'b0;
      gain_cnt     <= '0;
      ch           <= '0;
      phase        <= 1'b0;
      speeds.valid <= 1'b0;
      for (int i = 0; i < NCH; i++) begin
        wheel_target[i]  <= '0;
        wheel_command[i] <= '0;
        motor_speed[i]   <= '0;
      end
    end else begin
      if ((state == S_OUT) && out_free) begin
        speeds.valid <= 1'b1;
      end else if (speeds.ready) begin
        speeds.valid <= 1'b0;
      end
      if (gain_tag_out.valid) begin
        wheel_target[gain_tag_out.ch] <= gain_result;
      end
      case (state)
        S_IDLE: begin
          gain_cnt <= '0;
          ch       <= '0;
          phase    <= 1'b0;
          if (accept) begin
            if (item.data.operation == ssd_pkg::OP_COMMAND) begin
              idle_ticks <= '0;
              state      <= S_MAG;
            end else begin
              if (idle_ticks != '1) begin
                idle_ticks <= idle_ticks + 1'b1;
              end
              state <= S_AGE;
            end
          end
        end
        S_MAG: begin
          state <= S_CMP;
        end
        S_CMP: begin
          state <= norm_needed ? S_DIV_L : S_GAIN;
        end
        S_DIV_L: begin
          if (div_status.done) begin
            state <= S_DIV_R;
          end
        end
        S_DIV_R: begin
          if (div_status.done) begin
            state <= S_GAIN;
          end
        end
        S_GAIN: begin
          gain_cnt <= gain_cnt + 1'b1;
          if (gain_cnt[2]) begin
            state <= S_IDLE;
          end
        end
        S_AGE: begin
          if (idle_ticks > timeout_ticks) begin
            timed_out <= 1'b1;
            for (int i = 0; i < NCH; i++) begin
              wheel_target[i] <= '0;
            end
          end else begin
            timed_out <= 1'b0;
          end
          state <= S_SLEW;
        end
        S_SLEW: begin
          if (phase) begin
            motor_speed[ch] <= slew_result;
            ch              <= ch + 1'b1;
            if (ch == ssd_pkg::CH_WIDTH'(NCH - 1)) begin
              state <= S_OUT;
            end
          end else begin
            wheel_command[ch] <= slew_result;
          end
          phase <= !phase;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      left  <= XW'($signed(item.data.fwd_speed)) -
               XW'($signed(item.data.turn_rate));
      right <= XW'($signed(item.data.fwd_speed)) +
               XW'($signed(item.data.turn_rate));
    end
    if (state == S_MAG) begin
      mag_l <= left[XW-1] ? MW'(-left) : MW'(left);
      mag_r <= right[XW-1] ? MW'(-right) : MW'(right);
    end
    if (state == S_CMP && !norm_needed) begin
      base_l <= left[BW-1:0];
      base_r <= right[BW-1:0];
    end
    if (state == S_DIV_L && div_status.done) begin
      base_l <= left[XW-1] ? quot_neg : quot_pos;
    end
    if (state == S_DIV_R && div_status.done) begin
      base_r <= right[XW-1] ? quot_neg : quot_pos;
    end
    if (state == S_OUT && out_free) begin
      speeds.data.left_front_speed  <= motor_x[0][FW-1:0];
      speeds.data.left_rear_speed   <= motor_x[1][FW-1:0];
      speeds.data.right_front_speed <= motor_x[2][FW-1:0];
      speeds.data.right_rear_speed  <= motor_x[3][FW-1:0];
      speeds.data.timed_out         <= timed_out;
    end
  end

  `SSD_ASSERT_NEXT(a_command_restarts_idle, accept && (item.data.operation == ssd_pkg::OP_COMMAND), idle_ticks == '0, "idle counter not restarted by command")
  `SSD_ASSERT_NOW(a_timeout_clears_targets, (state == S_SLEW) && timed_out, (wheel_target[0] == '0) && (wheel_target[1] == '0) && (wheel_target[2] == '0) && (wheel_target[3] == '0), "targets not cleared on timeout")
  `SSD_ASSERT_NEXT(a_stall_holds_report, (state == S_OUT) && speeds.valid && !speeds.ready, state == S_OUT, "report step left while output stalled")

endmodule

/* bench/skid_steer_slew_limited_drive_tb.sv */
// Self-checking testbench of the skid-steer drive mixer: a directed table, then random bursts.
`timescale 1ns / 1ps

module skid_steer_slew_limited_drive_tb;

  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    ssd_pkg::item_t   it;
    bit               typed;
    ssd_pkg::result_t rpt;
  } plan_row_t;

  logic                                clk;
  logic                                rst;
  logic                                cfg_write;
  logic [ssd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [ssd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data;

  ssd_item_if   item_ch();
  ssd_result_if rpt_ch();

  skid_steer_slew_limited_drive dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .speeds    (rpt_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  longint  tgt_spd [ssd_pkg::CHANNELS];
  longint  cmd_spd [ssd_pkg::CHANNELS];
  longint  mot_spd [ssd_pkg::CHANNELS];
  longint  step_cmd, step_mot, dead_zone, gain_front, gain_rear, idle_limit;
  int      idle_count;
  ssd_pkg::result_t reports_due [$];

  int mismatches, n_commands, n_ticks, n_timeouts, n_checked, quiet_cycles;
  bit src_idle, snk_idle;

  plan_row_t plan [0:20] = '{
    '{{ssd_pkg::OP_TICK,    16'sh0000, 16'sh0000}, 1'b1, '0},
    '{{ssd_pkg::OP_COMMAND, 16'sh7FFF, 16'sh0000}, 1'b0, '0},
    '{{ssd_pkg::OP_TICK,    16'sh0000, 16'sh0000}, 1'b1,
      {16'sd8, 16'sd8, 16'sd8, 16'sd8, 1'b0}},
    '{{ssd_pkg::OP_COMMAND, 16'sh8000, 16'sh8000}, 1'b0, '0},
    '{{ssd_pkg::OP_TICK,    16'sh7FFF, 16'sh8000}, 1'b0, '0},
    '{{ssd_pkg::OP_COMMAND, 16'sh0000, 16'sh7FFF}, 1'b0, '0},
    '{{ssd_pkg::OP_TICK,    16'sh0000, 16'sh0000}, 1'b0, '0},
    '{{ssd_pkg::OP_COMMAND, 16'sh8000, 16'sh7FFF}, 1'b0, '0},
    '{{ssd_pkg::OP_TICK,    16'sh0000, 16'sh0000}, 1'b0, '0},
    '{{ssd_pkg::OP_COMMAND, 16'sh0001, 16'shFFFF}, 1'b0, '0},
    '{{ssd_pkg::OP_TICK,    16'sh0000, 16'sh0000}, 1'b0, '0},
    '{{ssd_pkg::OP_TICK,    16'sh0000, 16'sh0000}, 1'b0, '0},
    '{{ssd_pkg::OP_COMMAND, 16'sh1000, 16'sh0000}, 1'b0, '0},
    '{{ssd_pkg::OP_TICK,    16'sh0000, 16'sh0000}, 1'b0, '0},
    '{{ssd_pkg::OP_COMMAND, 16'sh1001, 16'sh0001}, 1'b0, '0},
    '{{ssd_pkg::OP_TICK,    16'sh0000, 16'sh0000}, 1'b0, '0},
    '{{ssd_pkg::OP_COMMAND, 16'shF000, 16'sh1000}, 1'b0, '0},
    '{{ssd_pkg::OP_TICK,    16'sh0000, 16'sh0000}, 1'b0, '0},
    '{{ssd_pkg::OP_TICK,    16'sh0000, 16'sh0000}, 1'b0, '0},
    '{{ssd_pkg::OP_COMMAND, 16'sh5555, 16'shAAAA}, 1'b0, '0},
    '{{ssd_pkg::OP_TICK,    16'shFFFF, 16'shFFFF}, 1'b0, '0}
  };

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic longint magnitude(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint scale_gain(input longint base, input longint gain);
    longint p, m;
    p = base * gain;
    m = (magnitude(p) + ssd_pkg::UNIT_VALUE / 2) >>> ssd_pkg::FRAC_BITS;
    m = p < 0 ? -m : m;
    if (m > 32767) m = 32767;
    else if (m < -32768) m = -32768;
    return m;
  endfunction

  function automatic longint slew_to(input longint value, input longint target,
                                     input longint step);
    longint d;
    d = target - value;
    if (magnitude(d) > step) return d > 0 ? value + step : value - step;
    return target;
  endfunction

  function automatic void reset_model();
    for (int i = 0; i < ssd_pkg::CHANNELS; i++) begin
      tgt_spd[i] = 0;
      cmd_spd[i] = 0;
      mot_spd[i] = 0;
    end
    step_cmd   = 410;
    step_mot   = 8;
    dead_zone  = 205;
    gain_front = 4096;
    gain_rear  = 4096;
    idle_limit = 50;
    idle_count = 0;
  endfunction

  function automatic void predict_drive(input ssd_pkg::item_t it, output bit has_rpt,
                                        output ssd_pkg::result_t rpt);
    longint left, right, ml, mr, mx, c;
    has_rpt = 1'b0;
    rpt     = '0;
    if (it.operation == ssd_pkg::OP_COMMAND) begin
      left  = longint'(it.fwd_speed) - longint'(it.turn_rate);
      right = longint'(it.fwd_speed) + longint'(it.turn_rate);
      ml = magnitude(left);
      mr = magnitude(right);
      mx = ml > mr ? ml : mr;
      if (mx > ssd_pkg::UNIT_VALUE) begin
        ml    = ml * ssd_pkg::UNIT_VALUE / mx;
        mr    = mr * ssd_pkg::UNIT_VALUE / mx;
        left  = left < 0 ? -ml : ml;
        right = right < 0 ? -mr : mr;
      end
      tgt_spd[0] = scale_gain(left, gain_front);
      tgt_spd[1] = scale_gain(left, gain_rear);
      tgt_spd[2] = scale_gain(right, gain_front);
      tgt_spd[3] = scale_gain(right, gain_rear);
      idle_count = 0;
    end else begin
      if (idle_count < 65535) idle_count++;
      if (idle_count > idle_limit) begin
        for (int i = 0; i < ssd_pkg::CHANNELS; i++) tgt_spd[i] = 0;
        rpt.timed_out = 1'b1;
      end
      for (int i = 0; i < ssd_pkg::CHANNELS; i++) begin
        c = slew_to(cmd_spd[i], tgt_spd[i], step_cmd);
        if (magnitude(c) < dead_zone) c = 0;
        cmd_spd[i] = c;
        mot_spd[i] = slew_to(mot_spd[i], c, step_mot);
      end
      rpt.left_front_speed  = 16'(mot_spd[0]);
      rpt.left_rear_speed   = 16'(mot_spd[1]);
      rpt.right_front_speed = 16'(mot_spd[2]);
      rpt.right_rear_speed  = 16'(mot_spd[3]);
      has_rpt = 1'b1;
    end
  endfunction

  task automatic note_error(input string msg);
    if (mismatches < 50) $display("ERROR at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_report(input ssd_pkg::result_t got, input ssd_pkg::result_t want);
    if (got.left_front_speed !== want.left_front_speed)
      note_error($sformatf("left_front_speed %0d, expected %0d",
                           got.left_front_speed, want.left_front_speed));
    if (got.left_rear_speed !== want.left_rear_speed)
      note_error($sformatf("left_rear_speed %0d, expected %0d",
                           got.left_rear_speed, want.left_rear_speed));
    if (got.right_front_speed !== want.right_front_speed)
      note_error($sformatf("right_front_speed %0d, expected %0d",
                           got.right_front_speed, want.right_front_speed));
    if (got.right_rear_speed !== want.right_rear_speed)
      note_error($sformatf("right_rear_speed %0d, expected %0d",
                           got.right_rear_speed, want.right_rear_speed));
    if (got.timed_out !== want.timed_out)
      note_error($sformatf("timed_out %0b, expected %0b", got.timed_out, want.timed_out));
  endtask

  function automatic int src_gap();
    return (src_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
  endfunction

  function automatic logic signed [ssd_pkg::FIELD_WIDTH-1:0] rand_speed();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 8192) - 4096);
      2: return 16'($urandom_range(0, 1024) - 512);
      default: begin
        case ($urandom_range(0, 4))
          0: return 16'sh7FFF;
          1: return 16'sh8000;
          2: return 16'sh0000;
          3: return 16'sh1000;
          default: return 16'shF000;
        endcase
      end
    endcase
  endfunction

  task automatic drive_item(input ssd_pkg::item_t it, input int gap, input bit drain,
                            input bit typed, input ssd_pkg::result_t typed_rpt);
    bit               has_rpt;
    ssd_pkg::result_t rpt;
    @(negedge clk);
    if (gap > 0 || drain) begin
      item_ch.valid <= 1'b0;
      repeat (gap > 0 ? gap : 1) @(negedge clk);
      while (drain && reports_due.size() != 0) @(negedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= it;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    predict_drive(it, has_rpt, rpt);
    if (has_rpt) reports_due.push_back(typed ? typed_rpt : rpt);
    if (it.operation == ssd_pkg::OP_TICK) n_ticks++;
    else n_commands++;
  endtask

  task automatic settle();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (reports_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [ssd_pkg::CFG_INDEX_WIDTH-1:0] idx,
                           input logic [ssd_pkg::CFG_DATA_WIDTH-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      ssd_pkg::REG_COMMAND_STEP:  step_cmd   = val[ssd_pkg::STEP_WIDTH-1:0];
      ssd_pkg::REG_MOTOR_STEP:    step_mot   = val[ssd_pkg::STEP_WIDTH-1:0];
      ssd_pkg::REG_DEAD_BAND:     dead_zone  = val[ssd_pkg::STEP_WIDTH-1:0];
      ssd_pkg::REG_FRONT_GAIN:    gain_front = longint'(signed'(val));
      ssd_pkg::REG_REAR_GAIN:     gain_rear  = longint'(signed'(val));
      ssd_pkg::REG_TIMEOUT_TICKS: idle_limit = val;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [15:0] cs, input logic [15:0] ms,
                               input logic [15:0] db, input logic [15:0] fg,
                               input logic [15:0] rg, input logic [15:0] tmo);
    write_reg(ssd_pkg::REG_COMMAND_STEP, cs);
    write_reg(ssd_pkg::REG_MOTOR_STEP, ms);
    write_reg(ssd_pkg::REG_DEAD_BAND, db);
    write_reg(ssd_pkg::REG_FRONT_GAIN, fg);
    write_reg(ssd_pkg::REG_REAR_GAIN, rg);
    write_reg(ssd_pkg::REG_TIMEOUT_TICKS, tmo);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Each burst is usually a command followed by a run of ticks, sometimes long enough
  // to reach the command timeout.
  task automatic run_bursts(input int items, input bit idling, input bit force_drain);
    int             sent, run;
    bit             drain;
    ssd_pkg::item_t it;
    sent  = 0;
    drain = force_drain;
    while (sent < items) begin
      src_idle = idling && $urandom_range(0, 2) != 0;
      snk_idle = idling && $urandom_range(0, 2) != 0;
      drain    = drain || (idling && $urandom_range(0, 19) == 0);
      if ($urandom_range(0, 9) < 7) begin
        it.operation = ssd_pkg::OP_COMMAND;
        it.fwd_speed = rand_speed();
        it.turn_rate = rand_speed();
        drive_item(it, src_gap(), drain, 1'b0, '0);
        drain = 1'b0;
        sent++;
      end
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 12);
      repeat (run) begin
        if (sent >= items) break;
        it.operation = ssd_pkg::OP_TICK;
        it.fwd_speed = 16'($urandom);
        it.turn_rate = 16'($urandom);
        drive_item(it, src_gap(), drain, 1'b0, '0);
        drain = 1'b0;
        sent++;
      end
    end
  endtask

  initial begin : receiver
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        rpt_ch.ready <= 1'b0;
        hold--;
      end else begin
        rpt_ch.ready <= 1'b1;
        if (snk_idle && $urandom_range(0, 4) == 0) hold = $urandom_range(1, 7);
      end
    end
  end

  always @(posedge clk) begin
    ssd_pkg::result_t got;
    if (!rst && rpt_ch.valid === 1'b1 && rpt_ch.ready === 1'b1) begin
      got = rpt_ch.data;
      n_checked++;
      if (got.timed_out) n_timeouts++;
      if (reports_due.size() == 0) note_error("speed report transfer with none expected");
      else compare_report(got, reports_due.pop_front());
    end
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
        (rpt_ch.valid === 1'b1 && rpt_ch.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles.", QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    item_ch.valid = 1'b0;
    item_ch.data  = '0;
    rpt_ch.ready  = 1'b0;
    src_idle      = 1'b0;
    snk_idle      = 1'b0;
    mismatches    = 0;
    n_commands    = 0;
    n_ticks       = 0;
    n_timeouts    = 0;
    n_checked     = 0;
    quiet_cycles  = 0;
    reset_model();
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    src_idle = 1'b1;
    snk_idle = 1'b1;
    for (int r = 0; r <= 20; r++) drive_item(plan[r].it, src_gap(), 1'b0, plan[r].typed,
                                             plan[r].rpt);
    settle();
    run_bursts(150, 1'b1, 1'b1);

    settle();
    apply_setting(16'd32767, 16'd32767, 16'd0, 16'h7FFF, 16'h8000, 16'd0);
    run_bursts(100, 1'b1, 1'b0);

    settle();
    apply_setting(16'd0, 16'd0, 16'd32767, 16'h8000, 16'h7FFF, 16'hFFFF);
    run_bursts(60, 1'b1, 1'b0);

    settle();
    apply_setting(16'($urandom_range(1, 2000)), 16'($urandom_range(1, 600)),
                  16'($urandom_range(0, 600)), 16'($urandom), 16'($urandom),
                  16'($urandom_range(0, 20)));
    run_bursts(160, 1'b1, 1'b0);

    settle();
    src_idle = 1'b0;
    snk_idle = 1'b0;
    apply_setting(16'($urandom_range(0, 32767)), 16'($urandom_range(0, 32767)),
                  16'($urandom_range(0, 32767)), 16'($urandom), 16'($urandom),
                  16'($urandom_range(0, 8)));
    run_bursts(160, 1'b0, 1'b0);

    settle();
    if (reports_due.size() != 0) note_error("speed reports still expected at the end");
    $display("Sent %0d commands and %0d ticks across five register settings, extremes included.",
             n_commands, n_ticks);
    $display("Checked %0d speed reports, %0d of them after a command timeout.",
             n_checked, n_timeouts);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* skid_steer_slew_limited_drive.f */
+incdir+src
src/ssd_pkg.sv
src/ssd_item_if.sv
src/ssd_result_if.sv
src/ssd_divider.sv
src/ssd_gain.sv
src/ssd_slew.sv
src/skid_steer_slew_limited_drive.sv
bench/skid_steer_slew_limited_drive_tb.sv
